FILE: rtl/fhd_pkg.sv
// Frame header deframer package: stream item types, status codes, phases,
// header layout constants and configuration reset values. No dependencies.
`default_nettype none

package fhd_pkg;

  localparam int HDR_LEN    = 20;
  localparam int VER_START  = 4;
  localparam int TYPE_START = 6;
  localparam int JSON_START = 8;
  localparam int ATT_START  = 12;

  localparam logic [7:0] MAGIC [4] = '{8'h44, 8'h54, 8'h52, 8'h57};  // "DTRW"

  localparam logic [15:0] PROTOCOL_VERSION_RST = 16'd1;
  localparam logic [31:0] JSON_LIMIT_RST       = 32'd16777216;
  localparam logic [63:0] ATTACHMENT_LIMIT_RST = 64'd1073741824;

  typedef enum logic [1:0] {
    REG_PROTOCOL_VERSION = 2'd0,
    REG_JSON_LIMIT       = 2'd1,
    REG_ATTACHMENT_LIMIT = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_JSON   = 2'd1,
    PH_ATTACH = 2'd2,
    PH_HALT   = 2'd3
  } phase_t;

  typedef enum logic [3:0] {
    ST_HEADER  = 4'd0,
    ST_JSON    = 4'd1,
    ST_ATTACH  = 4'd2,
    ST_CLEAN   = 4'd3,
    ST_EARLY   = 4'd4,
    ST_MAGIC   = 4'd5,
    ST_VERSION = 4'd6,
    ST_LENGTH  = 4'd7,
    ST_HALTED  = 4'd8
  } status_t;

  typedef struct packed {
    logic [15:0] protocol_version;
    logic [31:0] json_limit;
    logic [63:0] attachment_limit;
  } cfg_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  data_byte;
    logic        last_of_frame;
    logic [15:0] frame_type;
    logic [31:0] json_length;
    logic [63:0] attachment_length;
  } out_item_t;

endpackage

`default_nettype wire

FILE: rtl/fhd_stream_if.sv
// Valid/ready stream interface carrying one payload item per transaction.
// Payload type is set per channel from fhd_pkg item types.
`default_nettype none

interface fhd_stream_if #(
  parameter type item_t = logic
);
  logic  valid;
  logic  ready;
  item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: rtl/fhd_core.sv
// Deframer state and per-byte decode: header shift-in, checks, payload count.
// Produces one result item per accepted input. Depends on fhd_pkg.
`default_nettype none

module fhd_core (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire fhd_pkg::in_item_t item,
  input  wire fhd_pkg::cfg_t     cfg,
  output fhd_pkg::out_item_t     result
);

  fhd_pkg::phase_t phase, phase_next;
  logic [4:0]  header_index, header_index_next;
  logic        magic_ok, magic_ok_next;
  logic [15:0] version_field, version_field_next;
  logic [15:0] type_field, type_field_next;
  logic [31:0] json_field, json_field_next;
  logic [63:0] attachment_field, attachment_field_next;
  logic [63:0] remaining_bytes, remaining_bytes_next;

  fhd_pkg::status_t status;
  logic [7:0] data_byte;
  logic       last_of_frame;
  logic [7:0] b;

  assign b = item.byte_value;

  always_comb begin
    phase_next            = phase;
    header_index_next     = header_index;
    magic_ok_next         = magic_ok;
    version_field_next    = version_field;
    type_field_next       = type_field;
    json_field_next       = json_field;
    attachment_field_next = attachment_field;
    remaining_bytes_next  = remaining_bytes;
    status                = fhd_pkg::ST_HALTED;
    data_byte             = 8'd0;
    last_of_frame         = 1'b0;

    if (phase == fhd_pkg::PH_HALT) begin
      status = fhd_pkg::ST_HALTED;
    end else if (item.end_of_input) begin
      if (phase == fhd_pkg::PH_HEADER && header_index == 5'd0) begin
        status = fhd_pkg::ST_CLEAN;
      end else begin
        status     = fhd_pkg::ST_EARLY;
        phase_next = fhd_pkg::PH_HALT;
      end
    end else if (phase == fhd_pkg::PH_HEADER) begin
      status = fhd_pkg::ST_HEADER;
      priority if (header_index < 5'(fhd_pkg::VER_START)) begin
        if (b != fhd_pkg::MAGIC[header_index[1:0]]) begin
          magic_ok_next = 1'b0;
        end
      end else if (header_index < 5'(fhd_pkg::TYPE_START)) begin
        version_field_next = {version_field[7:0], b};
      end else if (header_index < 5'(fhd_pkg::JSON_START)) begin
        type_field_next = {type_field[7:0], b};
      end else if (header_index < 5'(fhd_pkg::ATT_START)) begin
        json_field_next = {json_field[23:0], b};
      end else begin
        attachment_field_next = {attachment_field[55:0], b};
      end

      if (header_index != 5'(fhd_pkg::HDR_LEN - 1)) begin
        header_index_next = header_index + 5'd1;
      end else begin
        header_index_next = 5'd0;
        // magic is final long before the last header byte
        priority if (!magic_ok) begin
          status     = fhd_pkg::ST_MAGIC;
          phase_next = fhd_pkg::PH_HALT;
        end else if (version_field_next != cfg.protocol_version) begin
          status     = fhd_pkg::ST_VERSION;
          phase_next = fhd_pkg::PH_HALT;
        end else if (json_field_next == 32'd0 || json_field_next > cfg.json_limit
                     || attachment_field_next > cfg.attachment_limit) begin
          status     = fhd_pkg::ST_LENGTH;
          phase_next = fhd_pkg::PH_HALT;
        end else begin
          phase_next           = fhd_pkg::PH_JSON;
          remaining_bytes_next = 64'(json_field_next);
        end
      end
    end else begin
      status    = (phase == fhd_pkg::PH_JSON) ? fhd_pkg::ST_JSON : fhd_pkg::ST_ATTACH;
      data_byte = b;
      // count reaches zero on this byte
      if (remaining_bytes <= 64'd1) begin
        remaining_bytes_next = 64'd0;
        if (phase == fhd_pkg::PH_JSON && attachment_field != 64'd0) begin
          phase_next           = fhd_pkg::PH_ATTACH;
          remaining_bytes_next = attachment_field;
        end else begin
          last_of_frame     = 1'b1;
          phase_next        = fhd_pkg::PH_HEADER;
          header_index_next = 5'd0;
          magic_ok_next     = 1'b1;
        end
      end else begin
        remaining_bytes_next = remaining_bytes - 64'd1;
      end
    end
  end

  always_comb begin
    result.status            = status;
    result.data_byte         = data_byte;
    result.last_of_frame     = last_of_frame;
    result.frame_type        = type_field_next;
    result.json_length       = json_field_next;
    result.attachment_length = attachment_field_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= fhd_pkg::PH_HEADER;
      header_index     <= 5'd0;
      magic_ok         <= 1'b1;
      version_field    <= 16'd0;
      type_field       <= 16'd0;
      json_field       <= 32'd0;
      attachment_field <= 64'd0;
      remaining_bytes  <= 64'd0;
    end else if (accept) begin
      phase            <= phase_next;
      header_index     <= header_index_next;
      magic_ok         <= magic_ok_next;
      version_field    <= version_field_next;
      type_field       <= type_field_next;
      json_field       <= json_field_next;
      attachment_field <= attachment_field_next;
      remaining_bytes  <= remaining_bytes_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/fhd_out_buf.sv
// Result register with a skid entry: registered ready toward the input side.
// Depends on fhd_pkg for the result item type.
`default_nettype none

module fhd_out_buf (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire fhd_pkg::out_item_t in_item,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output fhd_pkg::out_item_t      out_item
);

  fhd_pkg::out_item_t skid;
  logic               skid_valid;

  assign in_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !out_ready) begin
      // stalled: park a new transaction in the skid entry
      if (in_valid && in_ready) begin
        skid       <= in_item;
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_item   <= skid;
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_item  <= in_item;
      out_valid <= in_valid;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/frame_header_deframer.sv
// Frame header deframer top level: configuration registers, decode core and
// result buffer. Depends on fhd_pkg, fhd_stream_if, fhd_core, fhd_out_buf.
//
// Usage:
//   byte_in carries one stream byte or an end marker per transaction;
//   result_out gives exactly one result per accepted input, in order.
//   Each frame is a 20-byte header (magic, version, type, JSON length,
//   attachment length) followed by JSON and attachment bytes. The header is
//   checked on its last byte; an error or an early end halts the block and
//   every later input returns the halted status until reset.
//   Results are registered in the output buffer. Inputs are taken at one
//   byte per cycle while byte_in.ready is high; the per-byte decode and
//   the 64-bit payload count update sit between the input and the result
//   register. A two-entry output buffer (result register plus skid entry)
//   keeps byte_in.ready registered; with the receiver stalled, one more
//   input is taken and then ready drops until the result is taken.
//   Reset (rst, synchronous) clears the decode state, empties the buffer and
//   loads the register defaults. Config writes (cfg_we, cfg_index, cfg_data)
//   take effect in the next cycle; index 3 is ignored.
`default_nettype none

module frame_header_deframer (
  input  wire logic   clk,
  input  wire logic   rst,
  fhd_stream_if.sink   byte_in,
  fhd_stream_if.source result_out,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  fhd_pkg::cfg_t      cfg;
  fhd_pkg::out_item_t core_result;
  logic               accept;
  logic               buf_in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.protocol_version <= fhd_pkg::PROTOCOL_VERSION_RST;
      cfg.json_limit       <= fhd_pkg::JSON_LIMIT_RST;
      cfg.attachment_limit <= fhd_pkg::ATTACHMENT_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fhd_pkg::REG_PROTOCOL_VERSION: cfg.protocol_version <= cfg_data[15:0];
        fhd_pkg::REG_JSON_LIMIT:       cfg.json_limit       <= cfg_data[31:0];
        fhd_pkg::REG_ATTACHMENT_LIMIT: cfg.attachment_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  assign byte_in.ready = buf_in_ready;
  assign accept        = byte_in.valid && buf_in_ready;

  fhd_core u_core (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (byte_in.payload),
    .cfg    (cfg),
    .result (core_result)
  );

  fhd_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .in_ready  (buf_in_ready),
    .in_item   (core_result),
    .out_valid (result_out.valid),
    .out_ready (result_out.ready),
    .out_item  (result_out.payload)
  );

endmodule

`default_nettype wire

FILE: rtl/fhd_checker.sv
// Port-level checks for frame_header_deframer, bound to the top level.
// Depends on fhd_pkg and fhd_stream_if.
`default_nettype none

module fhd_checker (
  input wire logic     clk,
  input wire logic     rst,
  fhd_stream_if.sink   byte_in,
  fhd_stream_if.source result_out
);

  logic out_fire;
  logic halted_seen;

  assign out_fire = result_out.valid && result_out.ready;

  // any error or early end seen on the output latches the halted expectation
  always_ff @(posedge clk) begin
    if (rst) begin
      halted_seen <= 1'b0;
    end else if (out_fire && (result_out.payload.status == fhd_pkg::ST_EARLY
                              || result_out.payload.status == fhd_pkg::ST_MAGIC
                              || result_out.payload.status == fhd_pkg::ST_VERSION
                              || result_out.payload.status == fhd_pkg::ST_LENGTH)) begin
      halted_seen <= 1'b1;
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !result_out.valid)
    else $error("result valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    result_out.valid && !result_out.ready |=> result_out.valid && $stable(result_out.payload))
    else $error("stalled result changed");

  a_ready_low_only_full: assert property (@(posedge clk) disable iff (rst)
    !byte_in.ready |-> result_out.valid)
    else $error("input stalled with no pending result");

  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    out_fire && halted_seen |-> result_out.payload.status == fhd_pkg::ST_HALTED)
    else $error("output after an error is not halted");

  a_data_only_payload: assert property (@(posedge clk) disable iff (rst)
    result_out.valid && result_out.payload.status != fhd_pkg::ST_JSON
    && result_out.payload.status != fhd_pkg::ST_ATTACH
    |-> result_out.payload.data_byte == 8'd0 && !result_out.payload.last_of_frame)
    else $error("data or last marker outside payload");

endmodule

bind frame_header_deframer fhd_checker u_fhd_checker (
  .clk        (clk),
  .rst        (rst),
  .byte_in    (byte_in),
  .result_out (result_out)
);

`default_nettype wire
